FILE: rtl/lkv_pkg.sv
package lkv_pkg;

	// configuration port
	localparam int CfgIndexBits = 8;
	localparam int CfgDataBits  = 16;

	localparam logic [CfgIndexBits-1:0] REG_CAPACITY  = 8'd0;
	localparam logic [CfgIndexBits-1:0] REG_CLIENT_ID = 8'd1;

	localparam logic [4:0] CapacityReset = 5'd16;

	// operation codes
	typedef enum logic [1:0] {
		OP_GET        = 2'd0,
		OP_PUT        = 2'd1,
		OP_ERASE      = 2'd2,
		OP_INVALIDATE = 2'd3
	} op_t;

	// request payload
	typedef struct packed {
		op_t         op;
		logic [63:0] lookup_key;
		logic [63:0] write_value;
		logic [15:0] sender_id;
		logic        sender_present;
	} req_t;

	// response payload
	typedef struct packed {
		logic        found;
		logic [63:0] read_value;
	} rsp_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic promote;
		logic write_val;
		logic remove;
		logic insert;
		logic evict_en;
	} cell_ctrl_t;

endpackage

FILE: rtl/lkv_cell.sv
module lkv_cell #(
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64,
	parameter int RANK_BITS  = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lkv_pkg::cell_ctrl_t    ctrl,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [VALUE_BITS-1:0]  value,
	input  logic [RANK_BITS-1:0]   hit_rank,
	input  logic [RANK_BITS-1:0]   last_rank,
	input  logic                   free_in,
	output logic                   free_out,
	output logic                   match,
	output logic [RANK_BITS-1:0]   rank,
	output logic [VALUE_BITS-1:0]  stored_value
);

	logic                  valid_q;
	logic [RANK_BITS-1:0]  rank_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	logic                  valid_d;
	logic [RANK_BITS-1:0]  rank_d;
	logic                  key_we;
	logic                  val_we;
	logic                  victim;
	logic                  free;
	logic                  claim;

	// associative compare
	assign match = valid_q && (key_q == key);

	// least recent entry goes when the store is full
	assign victim = ctrl.evict_en && valid_q && (rank_q == last_rank);

	// lowest free slot: a claim ripples up the row
	assign free     = !valid_q || victim;
	assign free_out = free_in || free;
	assign claim    = ctrl.insert && free && !free_in;

	assign rank         = rank_q;
	assign stored_value = value_q;

	// next entry state
	always_comb begin
		valid_d = valid_q;
		rank_d  = rank_q;
		key_we  = 1'b0;
		val_we  = 1'b0;
		if (ctrl.promote) begin
			if (match) begin
				rank_d = '0;
				val_we = ctrl.write_val;
			end else if (valid_q && (rank_q < hit_rank)) begin
				rank_d = rank_q + RANK_BITS'(1);
			end
		end else if (ctrl.remove) begin
			if (match) begin
				valid_d = 1'b0;
				rank_d  = '0;
			end else if (valid_q && (rank_q > hit_rank)) begin
				rank_d = rank_q - RANK_BITS'(1);
			end
		end else if (ctrl.insert) begin
			if (claim) begin
				valid_d = 1'b1;
				rank_d  = '0;
				key_we  = 1'b1;
				val_we  = 1'b1;
			end else if (victim) begin
				valid_d = 1'b0;
				rank_d  = '0;
			end else if (valid_q) begin
				rank_d = rank_q + RANK_BITS'(1);
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else begin
			valid_q <= valid_d;
			rank_q  <= rank_d;
		end
	end

	// key and value storage
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_q <= key;
		end
		if (val_we) begin
			value_q <= value;
		end
	end

endmodule

FILE: rtl/lru_key_value_cache_top.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | lkv_pkg::req_t
// rsp     | out       | rsp_valid/rsp_ready  | lkv_pkg::rsp_t
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// one request per cycle unless a response is held; request stage, then response register
// the whole row of cells compares in the request stage and updates as that stage advances
// a response held by rsp_ready low stalls the request stage, then req_ready drops
// cfg_ready is always high; unknown register indexes are dropped
// reset empties every entry, capacity returns to 16 and client id to 0
module lru_key_value_cache_top #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  lkv_pkg::req_t                     req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output lkv_pkg::rsp_t                     rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lkv_pkg::CfgIndexBits-1:0]  cfg_index,
	input  logic [lkv_pkg::CfgDataBits-1:0]   cfg_data
);

	localparam int RB = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OB = $clog2(ENTRIES + 1);
	localparam int CW = (OB > 5) ? OB : 5;

	// configuration registers
	logic [4:0]  cap_q;
	logic [15:0] client_q;

	// request stage and response register
	logic          v_s1;
	lkv_pkg::req_t req_s1;
	logic          rsp_valid_q;
	lkv_pkg::rsp_t rsp_q;
	logic          adv;

	logic [OB-1:0] occ_q;

	// row signals
	lkv_pkg::cell_ctrl_t    ctrl;
	logic [KEY_BITS-1:0]    key;
	logic [VALUE_BITS-1:0]  wval;
	logic [RB-1:0]          hit_rank;
	logic [RB-1:0]          last_rank;
	logic [ENTRIES:0]       free_chain;
	logic [ENTRIES-1:0]     match;
	logic [RB-1:0]          rank_arr  [ENTRIES];
	logic [VALUE_BITS-1:0]  value_arr [ENTRIES];
	logic                   hit;
	logic [VALUE_BITS-1:0]  hit_value;

	// decoded operation
	logic is_get;
	logic is_put;
	logic is_erase;
	logic is_inval;
	logic ignore;
	logic evict_cond;

	logic [CW-1:0] cap_w;
	logic [CW-1:0] cap_eff;
	logic [CW-1:0] occ_w;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= lkv_pkg::CapacityReset;
			client_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lkv_pkg::REG_CAPACITY:  cap_q    <= cfg_data[4:0];
				lkv_pkg::REG_CLIENT_ID: client_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign adv       = v_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !v_s1 || adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				v_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// operation decode
	always_comb begin
		is_get   = 1'b0;
		is_put   = 1'b0;
		is_erase = 1'b0;
		is_inval = 1'b0;
		unique case (req_s1.op)
			lkv_pkg::OP_GET:        is_get   = 1'b1;
			lkv_pkg::OP_PUT:        is_put   = 1'b1;
			lkv_pkg::OP_ERASE:      is_erase = 1'b1;
			lkv_pkg::OP_INVALIDATE: is_inval = 1'b1;
			default: ;
		endcase
	end

	assign ignore = req_s1.sender_present && (req_s1.sender_id == client_q);
	assign key    = req_s1.lookup_key[KEY_BITS-1:0];
	assign wval   = req_s1.write_value[VALUE_BITS-1:0];

	// effective capacity, clamped to 1..ENTRIES
	assign cap_w = CW'(cap_q);
	assign occ_w = CW'(occ_q);
	always_comb begin
		priority if (cap_w == '0) begin
			cap_eff = CW'(1);
		end else if (cap_w > CW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end else begin
			cap_eff = cap_w;
		end
	end
	assign evict_cond = occ_w >= cap_eff;
	assign last_rank  = RB'(occ_q - OB'(1));

	// hit reduction across the row
	always_comb begin
		hit       = 1'b0;
		hit_rank  = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit       = hit | match[i];
			hit_rank  = hit_rank | (match[i] ? rank_arr[i] : '0);
			hit_value = hit_value | (match[i] ? value_arr[i] : '0);
		end
	end

	// command to the row
	always_comb begin
		ctrl.promote   = adv && hit && (is_get || is_put);
		ctrl.write_val = is_put;
		ctrl.remove    = adv && hit && (is_erase || (is_inval && !ignore));
		ctrl.evict_en  = adv && is_put && !hit && evict_cond;
		ctrl.insert    = adv && is_put && !hit && free_chain[ENTRIES];
	end

	// row of cells
	assign free_chain[0] = 1'b0;
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lkv_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.RANK_BITS  (RB)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.key          (key),
			.value        (wval),
			.hit_rank     (hit_rank),
			.last_rank    (last_rank),
			.free_in      (free_chain[g]),
			.free_out     (free_chain[g+1]),
			.match        (match[g]),
			.rank         (rank_arr[g]),
			.stored_value (value_arr[g])
		);
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctrl.remove) begin
			occ_q <= occ_q - OB'(1);
		end else if (ctrl.insert) begin
			occ_q <= occ_q + OB'(1) - OB'(ctrl.evict_en);
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.found      <= hit;
			rsp_q.read_value <= (is_get && hit) ? 64'(hit_value) : 64'd0;
		end
	end

endmodule

FILE: rtl/lkv_checker.sv
module lkv_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input lkv_pkg::req_t                     req,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input lkv_pkg::rsp_t                     rsp,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [lkv_pkg::CfgIndexBits-1:0]  cfg_index,
	input logic [lkv_pkg::CfgDataBits-1:0]   cfg_data
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// a miss never carries data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.read_value == 64'd0)
		else $error("read value without a hit");

	// requests stall only behind a blocked response
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request stalled without back pressure");

	// a fresh response comes from a request that was taken and passed through the request stage
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response without a request");

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (.*);
